FILE: src/hedc_pkg.sv
package hedc_pkg;

   localparam int unsigned NUM_DIGITS = 4;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned POS_W      = 2;
   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned SELECT_W   = 4;
   localparam int unsigned CSR_DATA_W = 8;

   typedef logic [DIGIT_W-1:0]    digit_type;
   typedef logic [POS_W-1:0]      scan_pos_type;
   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [SELECT_W-1:0]   select_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_SCAN   = 1'b1;

   // register indexes
   typedef enum logic [0:0] {
      CSR_LOW_THRESHOLD  = 1'b0,
      CSR_HIGH_THRESHOLD = 1'b1
   } csr_index_type;

   localparam sample_type LOW_THRESHOLD_RESET  = 8'd184;
   localparam sample_type HIGH_THRESHOLD_RESET = 8'd225;

   // event count after reset, 0 .. 9999
   localparam int unsigned START_COUNT = 998;

   localparam digit_type DIGIT_MAX  = 4'd9;
   localparam digit_type DIGIT_ZERO = 4'd0;

   // active-low digit enables
   localparam select_type SEL_UNITS     = 4'h7;
   localparam select_type SEL_TENS      = 4'hB;
   localparam select_type SEL_HUNDREDS  = 4'hD;
   localparam select_type SEL_THOUSANDS = 4'hE;
   localparam select_type SEL_ALL_OFF   = 4'hF;

   localparam scan_pos_type POS_UNITS     = 2'd0;
   localparam scan_pos_type POS_TENS      = 2'd1;
   localparam scan_pos_type POS_HUNDREDS  = 2'd2;
   localparam scan_pos_type POS_THOUSANDS = 2'd3;

   // control that every digit cell sees
   typedef struct packed {
      logic inc;    // this item adds one to the count
      logic latch;  // copy the live digit into the display latch
   } cell_ctrl_type;

   function automatic select_type select_code(input scan_pos_type pos);
      select_type code;
      unique case (pos)
         POS_UNITS:     code = SEL_UNITS;
         POS_TENS:      code = SEL_TENS;
         POS_HUNDREDS:  code = SEL_HUNDREDS;
         POS_THOUSANDS: code = SEL_THOUSANDS;
         default:       code = SEL_ALL_OFF;
      endcase
      return code;
   endfunction

   // decimal digit of START_COUNT, units first
   function automatic digit_type start_digit(input int unsigned idx);
      int unsigned d;
      unique case (idx)
         0:       d = START_COUNT % 10;
         1:       d = (START_COUNT / 10) % 10;
         2:       d = (START_COUNT / 100) % 10;
         default: d = (START_COUNT / 1000) % 10;
      endcase
      return d[DIGIT_W-1:0];
   endfunction

endpackage

FILE: src/hedc_if.sv
interface hedc_req_if;
   import hedc_pkg::*;

   logic       valid;
   logic       ready;
   logic       kind;
   sample_type sample;

   modport source (output valid, kind, sample, input ready);
   modport sink (input valid, kind, sample, output ready);
endinterface

interface hedc_rsp_if;
   import hedc_pkg::*;

   logic       valid;
   logic       ready;
   select_type digit_select;
   digit_type  digit_value;
   logic       event_counted;

   modport source (output valid, digit_select, digit_value, event_counted, input ready);
   modport sink (input valid, digit_select, digit_value, event_counted, output ready);
endinterface

FILE: src/hedc_detector.sv
module hedc_detector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  hedc_pkg::csr_index_type csr_index,
   input  hedc_pkg::csr_data_type csr_wdata,
   input  logic                   sample_take,
   input  hedc_pkg::sample_type   sample,
   output logic                   counted
);
   import hedc_pkg::*;

   sample_type low_ff, low_in;
   sample_type high_ff, high_in;
   logic       armed_ff, armed_in;
   logic       arm_now;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:  low_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_HIGH_THRESHOLD: high_in = csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // arm test first, then the count test on the updated armed bit
   assign arm_now = armed_ff | (sample < low_ff);
   assign counted = sample_take & arm_now & (sample > high_ff);

   always_comb begin
      armed_in = armed_ff;
      if (sample_take) begin
         armed_in = arm_now & ~counted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= LOW_THRESHOLD_RESET;
         high_ff  <= HIGH_THRESHOLD_RESET;
         armed_ff <= 1'b0;
      end else begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         armed_ff <= armed_in;
      end
   end

endmodule

FILE: src/hedc_digit_cell.sv
module hedc_digit_cell #(
   parameter logic [3:0] RESET_DIGIT = 4'd0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hedc_pkg::cell_ctrl_type ctrl,
   input  logic                    carry_in,
   output logic                    carry_out,
   output hedc_pkg::digit_type     digit,
   output hedc_pkg::digit_type     latched
);
   import hedc_pkg::*;

   digit_type digit_ff, digit_in;
   digit_type latched_ff, latched_in;
   logic      at_max;

   assign at_max    = (digit_ff == DIGIT_MAX);
   assign carry_out = carry_in & at_max;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.inc && carry_in) begin
         digit_in = at_max ? DIGIT_ZERO : digit_ff + DIGIT_W'(1);
      end
      latched_in = ctrl.latch ? digit_ff : latched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff   <= RESET_DIGIT;
         latched_ff <= DIGIT_ZERO;
      end else begin
         digit_ff   <= digit_in;
         latched_ff <= latched_in;
      end
   end

   assign digit   = digit_ff;
   assign latched = latched_ff;

endmodule

FILE: src/hysteresis_event_counter_display_core.sv
// Hysteresis event counter with a four-digit scanned BCD display. Each item on
// req_ch is either a converter sample (kind 0) or a display scan tick (kind 1),
// and each gives exactly one item on rsp_ch. A sample below the low threshold
// arms the detector; an armed detector that then sees a sample above the high
// threshold disarms and bumps the decimal event count (9999 wraps to 0,
// reset value 998); the result flags that with event_counted. A scan tick
// drives the next digit (units, tens, hundreds, thousands) with its active-low
// select, snapshotting the count at the units step; sample results repeat the
// current display drive. Thresholds are written through csr_we/csr_index/
// csr_wdata (index 0 low, 1 high) by the user only while the block is idle;
// it is not enforced. Rate: one item per clock unless rsp_ch stalls; results
// are registered. The count lives in a ripple chain of four decade cells, so
// all state updates in the accepting cycle; a single output register holds
// the result and req_ch.ready stays high while it is empty or being taken.
module hysteresis_event_counter_display_core (
   input  logic                    clock,
   input  logic                    reset,
   hedc_req_if.sink                req_ch,
   hedc_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  hedc_pkg::csr_index_type csr_index,
   input  hedc_pkg::csr_data_type  csr_wdata
);
   import hedc_pkg::*;

   // handshake
   logic req_accept;
   logic sample_take;
   logic scan_take;

   // detector
   logic counted;

   // digit chain, units first
   cell_ctrl_type cell_ctrl;
   logic          carry [NUM_DIGITS+1];
   digit_type     live_digit [NUM_DIGITS];
   digit_type     latched_digit [NUM_DIGITS];

   // display scan
   scan_pos_type scan_pos_ff, scan_pos_in;
   select_type   drive_select_ff, drive_select_in;
   digit_type    drive_value_ff, drive_value_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   select_type rsp_select_ff, rsp_select_in;
   digit_type  rsp_value_ff, rsp_value_in;
   logic       rsp_counted_ff, rsp_counted_in;

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign req_accept   = req_ch.valid & req_ch.ready;
   assign sample_take  = req_accept & (req_ch.kind == KIND_SAMPLE);
   assign scan_take    = req_accept & (req_ch.kind == KIND_SCAN);

   hedc_detector u_detector (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .sample_take (sample_take),
      .sample      (req_ch.sample),
      .counted     (counted)
   );

   // snapshot taken on the units step of the scan
   assign cell_ctrl.inc   = counted;
   assign cell_ctrl.latch = scan_take & (scan_pos_ff == POS_UNITS);
   assign carry[0]        = 1'b1;

   for (genvar gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      hedc_digit_cell #(
         .RESET_DIGIT (start_digit(gi))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .carry_in  (carry[gi]),
         .carry_out (carry[gi+1]),
         .digit     (live_digit[gi]),
         .latched   (latched_digit[gi])
      );
   end

   // scan step: units shows the fresh snapshot, i.e. the live digit
   always_comb begin
      scan_pos_in     = scan_pos_ff;
      drive_select_in = drive_select_ff;
      drive_value_in  = drive_value_ff;
      if (scan_take) begin
         scan_pos_in     = scan_pos_ff + POS_W'(1);
         drive_select_in = select_code(scan_pos_ff);
         drive_value_in  = (scan_pos_ff == POS_UNITS) ? live_digit[0]
                                                     : latched_digit[scan_pos_ff];
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;
      rsp_select_in  = rsp_select_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_counted_in = rsp_counted_ff;
      if (req_accept) begin
         rsp_valid_in   = 1'b1;
         rsp_select_in  = drive_select_in;
         rsp_value_in   = drive_value_in;
         rsp_counted_in = counted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff     <= POS_UNITS;
         drive_select_ff <= SEL_ALL_OFF;
         drive_value_ff  <= DIGIT_ZERO;
         rsp_valid_ff    <= 1'b0;
      end else begin
         scan_pos_ff     <= scan_pos_in;
         drive_select_ff <= drive_select_in;
         drive_value_ff  <= drive_value_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_select_ff  <= rsp_select_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_counted_ff <= rsp_counted_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.digit_select  = rsp_select_ff;
   assign rsp_ch.digit_value   = rsp_value_ff;
   assign rsp_ch.event_counted = rsp_counted_ff;

   // every accepted item shows up as a result on the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // a pending result always carries the current display drive
   a_result_tracks_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_select_ff == drive_select_ff) && (rsp_value_ff == drive_value_ff))
      else $error("result drive differs from display drive");

   // at most one digit enabled at a time
   a_one_digit_driven: assert property (@(posedge clock) disable iff (reset)
      $onehot0(~drive_select_ff))
      else $error("more than one digit enabled");

   // decade cells stay in BCD range
   a_count_is_bcd: assert property (@(posedge clock) disable iff (reset)
      (live_digit[0] <= DIGIT_MAX) && (live_digit[1] <= DIGIT_MAX) &&
      (live_digit[2] <= DIGIT_MAX) && (live_digit[3] <= DIGIT_MAX))
      else $error("count digit out of BCD range");

endmodule

FILE: tb/hedc_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps a cycle-free model of the
// counter and display state, and compares every result item in order.
module hedc_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_kind,
   input  hedc_pkg::sample_type    req_sample,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hedc_pkg::select_type    rsp_digit_select,
   input  hedc_pkg::digit_type     rsp_digit_value,
   input  logic                    rsp_event_counted,
   input  logic                    csr_we,
   input  hedc_pkg::csr_index_type csr_index,
   input  hedc_pkg::csr_data_type  csr_wdata,
   output int unsigned             error_count,
   output int unsigned             pending_results,
   output int unsigned             checked_results,
   output int unsigned             counted_events,
   output int unsigned             count_wraps
);
   import hedc_pkg::*;

   typedef struct packed {
      select_type sel;
      digit_type  value;
      logic       counted;
   } display_result_type;

   display_result_type expected_display_q[$];

   sample_type   low_level_q;
   sample_type   high_level_q;
   logic [13:0]  tally_q;
   logic         armed_q;
   scan_pos_type scan_q;
   digit_type    frozen_digits_q [NUM_DIGITS];
   select_type   drive_sel_q;
   digit_type    drive_val_q;

   function automatic select_type digit_enable_for(input scan_pos_type pos);
      select_type code;
      case (pos)
         POS_UNITS:     code = SEL_UNITS;
         POS_TENS:      code = SEL_TENS;
         POS_HUNDREDS:  code = SEL_HUNDREDS;
         default:       code = SEL_THOUSANDS;
      endcase
      return code;
   endfunction

   task automatic clear_state();
      low_level_q  = LOW_THRESHOLD_RESET;
      high_level_q = HIGH_THRESHOLD_RESET;
      tally_q      = 14'(START_COUNT);
      armed_q      = 1'b0;
      scan_q       = POS_UNITS;
      for (int i = 0; i < NUM_DIGITS; i++) frozen_digits_q[i] = DIGIT_ZERO;
      drive_sel_q  = SEL_ALL_OFF;
      drive_val_q  = DIGIT_ZERO;
      expected_display_q.delete();
   endtask

   // Apply one accepted item to the model and queue the result it causes.
   task automatic predict_display(input logic kind, input sample_type level);
      display_result_type res;
      int unsigned        n;
      res.counted = 1'b0;
      if (kind == KIND_SAMPLE) begin
         // arm test first, count test sees the updated armed bit
         if (level < low_level_q) armed_q = 1'b1;
         if (armed_q && level > high_level_q) begin
            armed_q = 1'b0;
            if (tally_q >= 14'd9999) begin
               tally_q = '0;
               count_wraps++;
            end else begin
               tally_q = tally_q + 14'd1;
            end
            res.counted = 1'b1;
            counted_events++;
         end
      end else begin
         if (scan_q == POS_UNITS) begin
            n = tally_q % 10000;
            frozen_digits_q[3] = digit_type'(n / 1000);
            n = n % 1000;
            frozen_digits_q[2] = digit_type'(n / 100);
            n = n % 100;
            frozen_digits_q[1] = digit_type'(n / 10);
            frozen_digits_q[0] = digit_type'(n % 10);
         end
         drive_sel_q = digit_enable_for(scan_q);
         drive_val_q = frozen_digits_q[scan_q];
         scan_q      = scan_q + POS_TENS;
      end
      res.sel   = drive_sel_q;
      res.value = drive_val_q;
      expected_display_q.push_back(res);
   endtask

   task automatic check_display();
      display_result_type exp;
      if (expected_display_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR: result item with nothing expected: sel %h value %0d counted %b",
                     rsp_digit_select, rsp_digit_value, rsp_event_counted);
      end else begin
         exp = expected_display_q.pop_front();
         if (exp.sel !== rsp_digit_select || exp.value !== rsp_digit_value ||
             exp.counted !== rsp_event_counted) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: result %0d: expected sel %h value %0d counted %b, %s",
                        checked_results, exp.sel, exp.value, exp.counted,
                        $sformatf("got sel %h value %0d counted %b", rsp_digit_select,
                                  rsp_digit_value, rsp_event_counted));
         end
      end
      checked_results++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid && rsp_ready) check_display();
         if (csr_we) begin
            if (csr_index == CSR_LOW_THRESHOLD) low_level_q = csr_wdata;
            else high_level_q = csr_wdata;
         end
         if (req_valid && req_ready) predict_display(req_kind, req_sample);
      end
      pending_results = expected_display_q.size();
   end

endmodule

FILE: tb/tb_hysteresis_event_counter_display_core.sv
`timescale 1ns / 1ps

module tb_hysteresis_event_counter_display_core;
   import hedc_pkg::*;

   // generous for ~450 items, even under heavy stalls
   localparam int unsigned RUN_LIMIT = 50000;

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   hedc_req_if req_ch ();
   hedc_rsp_if rsp_ch ();

   int unsigned error_count;
   int unsigned pending_results;
   int unsigned checked_results;
   int unsigned counted_events;
   int unsigned count_wraps;

   int unsigned items_sent;
   int unsigned cycle_count;
   int unsigned send_idle_pct;   // chance per item of a gap on req_ch
   int unsigned rsp_idle_pct;    // chance per cycle of rsp_ch.ready low

   // thresholds as last written, used to aim samples at both sides
   sample_type low_thr;
   sample_type high_thr;

   hysteresis_event_counter_display_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hedc_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_kind          (req_ch.kind),
      .req_sample        (req_ch.sample),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_digit_select  (rsp_ch.digit_select),
      .rsp_digit_value   (rsp_ch.digit_value),
      .rsp_event_counted (rsp_ch.event_counted),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .pending_results   (pending_results),
      .checked_results   (checked_results),
      .counted_events    (counted_events),
      .count_wraps       (count_wraps)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: ready is redrawn every falling edge, held low in reset.
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99, 0) >= rsp_idle_pct);
   end

   // Watchdog. A hang or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_results);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Present one item at the falling edge, with random gaps ahead of it, and
   // hold it until an edge sees valid and ready together. valid stays high on
   // return so back-to-back items need no extra assignment.
   task automatic send_item(input logic kind, input sample_type level);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.sample <= level;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Mostly samples aimed below the low or above the high threshold, so the
   // detector keeps cycling through arm and count; the rest scan ticks and
   // uniform levels (which also toggle every sample bit).
   task automatic send_random_item();
      int unsigned pick;
      sample_type  level;
      pick  = $urandom_range(99, 0);
      level = sample_type'($urandom_range(255, 0));
      if (pick < 30) begin
         send_item(KIND_SCAN, level);
      end else begin
         if (pick < 60 && low_thr != 8'd0)
            level = sample_type'($urandom_range(int'(low_thr) - 1, 0));
         else if (pick >= 60 && pick < 90 && high_thr != 8'hFF)
            level = sample_type'($urandom_range(255, int'(high_thr) + 1));
         send_item(KIND_SAMPLE, level);
      end
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // Both registers, one per cycle; only called with the block drained.
   task automatic write_thresholds(input sample_type lo, input sample_type hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOW_THRESHOLD;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_HIGH_THRESHOLD;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we    <= 1'b0;
      low_thr  = lo;
      high_thr = hi;
   endtask

   initial begin
      sample_type lo;
      sample_type hi;
      int         setting;

      req_ch.valid  = 1'b0;
      req_ch.kind   = KIND_SAMPLE;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_LOW_THRESHOLD;
      csr_wdata     = '0;
      reset         = 1'b1;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      low_thr       = LOW_THRESHOLD_RESET;
      high_thr      = HIGH_THRESHOLD_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed, reset thresholds (184 / 225), count starts at 998 ----
      send_item(KIND_SCAN, 8'd0);      // latch 998, drive units
      send_item(KIND_SCAN, 8'd0);      // tens
      send_item(KIND_SAMPLE, 8'd0);    // lowest level arms; result repeats drive
      send_item(KIND_SAMPLE, 8'd255);  // highest level counts -> 999 mid-scan
      send_item(KIND_SCAN, 8'd0);      // hundreds still from the old snapshot
      send_item(KIND_SCAN, 8'd0);      // thousands
      send_item(KIND_SCAN, 8'd0);      // back to units: snapshot taken again
      send_item(KIND_SAMPLE, 8'd184);  // equal to low threshold: no arm
      send_item(KIND_SAMPLE, 8'd255);  // not armed: no count
      send_item(KIND_SAMPLE, 8'd183);  // just below: arms
      send_item(KIND_SAMPLE, 8'd225);  // equal to high threshold: no count
      send_item(KIND_SAMPLE, 8'd226);  // just above: count -> 1000
      send_item(KIND_SAMPLE, 8'd128);  // between thresholds: nothing
      send_item(KIND_SAMPLE, 8'd183);
      send_item(KIND_SAMPLE, 8'd183);  // arming twice is harmless
      send_item(KIND_SAMPLE, 8'd255);  // count -> 1001
      repeat (4) send_item(KIND_SCAN, 8'd0);  // rest of the 999 scan, then units latches 1001
      send_item(KIND_SCAN, 8'hFF);     // scan ticks ignore the sample field

      // ---- random phases: three idling patterns, three settings each ----
      // settings: reset values, extremes, crossed thresholds, random pairs
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 24;
               rsp_idle_pct  = 67;
            end
            1: begin
               send_idle_pct = 67;
               rsp_idle_pct  = 24;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            setting = phase * 3 + seg;
            case (setting)
               0: begin lo = 8'd184; hi = 8'd225; end
               1: begin lo = 8'd0;   hi = 8'd255; end  // can never arm or count
               2: begin lo = 8'd255; hi = 8'd0;   end  // nearly every sample counts
               3: begin lo = 8'd200; hi = 8'd100; end  // crossed: arm and count at once
               4: begin lo = 8'd0;   hi = 8'd0;   end
               5: begin lo = 8'd255; hi = 8'd255; end
               6: begin lo = 8'd64;  hi = 8'd192; end
               default: begin
                  lo = sample_type'($urandom_range(255, 0));
                  hi = sample_type'($urandom_range(255, 0));
               end
            endcase
            wait_drained();
            write_thresholds(lo, hi);
            repeat (45) send_random_item();
         end
      end

      // ---- short burst where nearly every sample arms and counts ----
      // With low 255 / high 0 every level 1..254 arms and counts in one item.
      wait_drained();
      write_thresholds(8'd255, 8'd0);
      repeat (25) begin
         if ($urandom_range(15, 0) == 0)
            send_item(KIND_SCAN, sample_type'($urandom_range(255, 0)));
         else
            send_item(KIND_SAMPLE, sample_type'($urandom_range(254, 1)));
      end
      repeat (4) send_item(KIND_SCAN, 8'd0);  // scan all four digits, latching the final count at units

      wait_drained();
      repeat (8) @(negedge clock);

      $display("Run covered %0d items and %0d checked results over 10 threshold settings",
               items_sent, checked_results);
      $display("with %0d events counted and %0d count wraps, under three stall patterns",
               counted_events, count_wraps);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/hedc_pkg.sv
src/hedc_if.sv
src/hedc_detector.sv
src/hedc_digit_cell.sv
src/hysteresis_event_counter_display_core.sv
tb/hedc_checker.sv
tb/tb_hysteresis_event_counter_display_core.sv
